// ===== rtl/psc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and codes of the packet sink classifier.
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef enum logic [1:0] {
    KIND_PKT = 2'd0,
    KIND_ADD = 2'd1,
    KIND_REM = 2'd2,
    KIND_NOP = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_DISCARDED = 3'd1,
    ST_BAD_CKSUM = 3'd2,
    ST_ADDED     = 3'd3,
    ST_BUSY      = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  // one rule entry as held in memory
  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  ip_proto;
    logic [31:0] host_ip;
    logic [31:0] peer_ip;
    logic [15:0] host_port;
    logic [15:0] peer_port;
    logic        own_ip;
    logic [2:0]  score;
    logic [31:0] stamp;
  } rule_t;

  // input beat, first field highest
  typedef struct packed {
    logic        match_own_ip;
    logic        checksum_ok;
    logic [1:0]  layers;
    logic [15:0] orig_port;
    logic [15:0] dest_port;
    logic [31:0] orig_ip;
    logic [31:0] dest_ip;
    logic [7:0]  ip_proto;
    logic [15:0] ether_type;
    logic [47:0] dest_mac;
    logic [2:0]  slot;
    logic [1:0]  kind;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] bad_checksum_total;
    logic [31:0] discard_total;
    logic [31:0] rx_total;
    logic [31:0] hit_count;
    logic [2:0]  hit_slot;
    logic [2:0]  status;
  } out_beat_t;

  function automatic logic [2:0] score_of(input in_beat_t b);
    score_of = 3'(((b.dest_ip != '0) || b.match_own_ip) ? 1 : 0)
             + 3'((b.orig_ip != '0) ? 1 : 0) + 3'((b.dest_port != '0) ? 1 : 0)
             + 3'((b.orig_port != '0) ? 1 : 0) + 3'((b.ether_type != '0) ? 1 : 0)
             + 3'((b.ip_proto != '0) ? 1 : 0);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/psc_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psc_match
// Match of one stored rule against the packet held in the work register.
// ----------------------------------------------------------------------------
module psc_match (
  input  var psc_pkg::rule_t    rule,
  input  var psc_pkg::in_beat_t pkt,
  input  wire logic [31:0]      own_ipv4,
  output logic                  hit
);
  import psc_pkg::*;

  logic has_ip, has_ports;

  // test every criterion; zero means wildcard
  always_comb begin
    has_ip    = (pkt.layers != 2'd0);
    has_ports = pkt.layers[1];
    hit = 1'b1;
    if (rule.ether_type != '0 && rule.ether_type != pkt.ether_type) hit = 1'b0;
    if (rule.ip_proto != '0 && !(has_ip && rule.ip_proto == pkt.ip_proto)) hit = 1'b0;
    if (rule.host_ip != '0 && !(has_ip && rule.host_ip == pkt.dest_ip)) hit = 1'b0;
    if (rule.own_ip && !(has_ip && own_ipv4 != '0 && own_ipv4 == pkt.dest_ip)) hit = 1'b0;
    if (rule.peer_ip != '0 && !(has_ip && rule.peer_ip == pkt.orig_ip)) hit = 1'b0;
    if (rule.host_port != '0 && !(has_ports && rule.host_port == pkt.dest_port))
      hit = 1'b0;
    if (rule.peer_port != '0 && !(has_ports && rule.peer_port == pkt.orig_port))
      hit = 1'b0;
  end

endmodule
`default_nettype wire

// ===== rtl/packet_sink_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_sink_classifier
// Receive classifier with a prioritised rule table held in memory.
// ----------------------------------------------------------------------------
// Each beat gives one result beat, except kind three, which is taken and
// dropped. Add and remove pass from idle to a state that decides on the
// valid bits and writes the rule, then to the state that presents the result,
// and back to idle once the result is taken; a packet dropped on its MAC or
// its checksum takes the same path. A packet that reaches the table scans the
// rule memory one slot per cycle over the single read port, then reads and
// writes back the hit count; that scan sets the rate. No new beat is taken
// until the result is taken, and a low out_tready holds the result. After
// reset the valid bits clear at once; no clearing pass.
module packet_sink_classifier #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // kind, slot, dest_mac, ether_type, ip_proto, dest_ip, orig_ip,
  // dest_port, orig_port, layers, checksum_ok, match_own_ip, pad
  input  wire logic [183:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status, hit_slot, hit_count, rx_total, discard_total, bad_checksum_total
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [47:0]  cfg_wdata
);
  import psc_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EVAL, S_SCAN, S_HITRD, S_HITWR, S_OUT} state_t;

  state_t      state_r;
  in_beat_t    beat_r;
  logic [2:0]  status_r, hslot_r;
  logic [31:0] hcount_r;
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [31:0] stamp_r, rx_r, disc_r, bad_r;
  logic [SLOTS-1:0] valid_r;
  logic [IW:0]  idx_r;
  logic [IW-1:0] best_r;
  logic         found_r, rd_ok_r;
  logic [2:0]   bscore_r;
  logic [31:0]  bage_r;

  // rule and hit memories
  rule_t       rule_mem [SLOTS];
  logic [31:0] hit_mem  [SLOTS];
  rule_t       rule_rd_r;
  logic [31:0] hit_rd_r;
  logic        rule_we, hit_we;
  logic [IW-1:0] rd_addr, wr_addr;
  rule_t       rule_wd;
  logic [31:0] hit_wd;

  in_beat_t ib;
  logic     hit, slot_ok, mac_ok;
  logic [31:0] age;

  assign ib = in_beat_t'(in_tdata[176:0]);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {2'b00, bad_r, disc_r, rx_r, hcount_r, hslot_r, status_r};
  assign slot_ok = ({29'd0, beat_r.slot} < 32'(SLOTS));
  assign mac_ok  = (beat_r.dest_mac == own_mac_r) || beat_r.dest_mac[40];
  assign age     = stamp_r - rule_rd_r.stamp;

  psc_match u_match (.rule(rule_rd_r), .pkt(beat_r), .own_ipv4(own_ip_r), .hit(hit));

  // memory ports
  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[wr_addr] <= rule_wd;
    if (hit_we)  hit_mem[wr_addr]  <= hit_wd;
    rule_rd_r <= rule_mem[rd_addr];
    hit_rd_r  <= hit_mem[rd_addr];
  end

  always_comb begin
    rd_addr = (state_r == S_SCAN) ? idx_r[IW-1:0] :
              (state_r == S_HITRD) ? best_r : IW'(beat_r.slot);
    wr_addr = (state_r == S_HITWR) ? best_r : IW'(beat_r.slot);
    rule_we = (state_r == S_EVAL) && beat_r.kind == KIND_ADD && slot_ok
              && !valid_r[IW'(beat_r.slot)];
    rule_wd = '{ether_type: beat_r.ether_type, ip_proto: beat_r.ip_proto,
                host_ip: beat_r.dest_ip, peer_ip: beat_r.orig_ip,
                host_port: beat_r.dest_port, peer_port: beat_r.orig_port,
                own_ip: beat_r.match_own_ip, score: score_of(beat_r), stamp: stamp_r};
    hit_we  = rule_we || (state_r == S_HITWR);
    hit_wd  = rule_we ? 32'd0 : hit_rd_r + 32'd1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; stamp_r <= '0; rx_r <= '0;
      disc_r <= '0; bad_r <= '0; own_mac_r <= '0; own_ip_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) own_mac_r <= cfg_wdata;
        else own_ip_r <= cfg_wdata[31:0];
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid && ib.kind != KIND_NOP) begin
          beat_r <= ib; state_r <= S_EVAL; idx_r <= '0;
        end
        S_EVAL: begin
          hcount_r <= '0;
          case (beat_r.kind)
            KIND_ADD: begin
              hslot_r <= beat_r.slot; state_r <= S_OUT;
              if (rule_we) begin
                valid_r[IW'(beat_r.slot)] <= 1'b1; stamp_r <= stamp_r + 32'd1;
                status_r <= ST_ADDED;
              end else status_r <= ST_BUSY;
            end
            KIND_REM: begin
              hslot_r <= beat_r.slot; state_r <= S_OUT;
              if (slot_ok && valid_r[IW'(beat_r.slot)]) begin
                valid_r[IW'(beat_r.slot)] <= 1'b0; status_r <= ST_REMOVED;
              end else status_r <= ST_NOT_FOUND;
            end
            default: begin
              hslot_r <= '0;
              rx_r <= rx_r + 32'd1;
              if (!mac_ok) begin
                disc_r <= disc_r + 32'd1; status_r <= ST_DISCARDED; state_r <= S_OUT;
              end else if (!beat_r.checksum_ok) begin
                bad_r <= bad_r + 32'd1; status_r <= ST_BAD_CKSUM; state_r <= S_OUT;
              end else begin
                found_r <= 1'b0; rd_ok_r <= 1'b0; state_r <= S_SCAN;
              end
            end
          endcase
        end
        S_SCAN: begin
          // evaluate the slot read last cycle, issue the next read
          if (rd_ok_r && valid_r[IW'(idx_r - 1'b1)] && hit &&
              (!found_r || rule_rd_r.score > bscore_r ||
               (rule_rd_r.score == bscore_r && age < bage_r))) begin
            found_r <= 1'b1; best_r <= IW'(idx_r - 1'b1);
            bscore_r <= rule_rd_r.score; bage_r <= age;
          end
          rd_ok_r <= 1'b1;
          if (idx_r == (IW+1)'(SLOTS)) state_r <= S_HITRD;
          else idx_r <= idx_r + 1'b1;
        end
        S_HITRD: if (found_r) state_r <= S_HITWR;
          else begin
            disc_r <= disc_r + 32'd1; status_r <= ST_DISCARDED; state_r <= S_OUT;
          end
        S_HITWR: begin
          status_r <= ST_DELIVERED; hslot_r <= 3'(best_r);
          hcount_r <= hit_wd; state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
